// ===== hdl/sstf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Widths, limits and beat types shared by the scheduler modules.
// ----------------------------------------------------------------------------
package sstf_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CYL_BITS     = 16;
	localparam int SUM_W        = 21;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W        = $clog2(MAX_REQUESTS);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef logic [CYL_BITS-1:0] cyl_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [SUM_W-1:0]    sum_t;

	typedef struct packed {
		logic [15:0] cylinder;
		logic        last_request;
	} req_t;

	typedef struct packed {
		logic [15:0]      served_cylinder;
		logic [15:0]      seek_distance;
		logic [SUM_W-1:0] total_traversed;
		logic             last_served;
	} res_t;

endpackage

// ===== hdl/sstf_dist_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF distance unit
// Absolute head distance to one candidate and the keep-or-replace decision.
// ----------------------------------------------------------------------------
module sstf_dist_unit import sstf_pkg::*; (
	input  cyl_t head,
	input  cyl_t cand,
	input  cyl_t best,
	input  logic found,
	input  logic served,
	output cyl_t seek,
	output logic take
);

	assign seek = (head >= cand) ? (head - cand) : (cand - head);
	// Ties go to the later candidate
	assign take = !served && (!found || (seek <= best));

endmodule

// ===== hdl/sstf_disk_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF disk scheduler
// Shortest-seek-time-first ordering of a batch of cylinder requests.
// ----------------------------------------------------------------------------
// Usage:
//   cfg   : one beat writes start_cylinder; cfg_ready is always high. Write it
//           only while the block is idle. It is sampled by the final request.
//   req   : one beat per request, taken one per cycle while loading. Requests
//           beyond MAX_REQUESTS are dropped; a beat with last_request set
//           still starts scheduling. req_ready falls until the batch is out.
//   res   : one beat per stored request, in service order, with last_served
//           set on the final beat of the batch.
// Timing: each result takes a scan of all N held requests through the single
//   distance/compare unit, reading them from the store, then a drain step for
//   the read register and an issue step. The scan for the first result starts
//   once the final request beat is taken.
// Stall: the result sits in an output register; while res_ready is low the
//   sequencer holds in its issue step and nothing is lost.
// Reset: count, served marks, head, total and start_cylinder clear; the
//   request store is not cleared, only entries of the current batch are read.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_top import sstf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]              state_q;
	cyl_t                    start_q;
	cnt_t                    count_q;
	cnt_t                    k_q;
	idx_t                    scan_idx_q;
	logic [MAX_REQUESTS-1:0] marks_q;
	cyl_t                    head_q;
	sum_t                    sum_q;
	cyl_t                    best_q;
	cyl_t                    pick_cyl_q;
	idx_t                    pick_idx_q;
	logic                    found_q;
	logic                    res_valid_q;
	res_t                    res_q;

	// Read stage of the request store
	cyl_t                    store [MAX_REQUESTS];
	cyl_t                    rd_data_s1;
	idx_t                    rd_idx_s1;
	logic                    rd_vld_s1;

	logic                    req_fire;
	logic                    room;
	cnt_t                    count_nxt;
	logic                    scan_last;
	logic                    emit_go;
	logic                    batch_last;
	cyl_t                    cand_seek;
	logic                    take;
	logic [SUM_W:0]          sum_ext;
	sum_t                    sum_new;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign room      = (count_q < CNT_W'(MAX_REQUESTS));
	assign count_nxt = room ? (count_q + cnt_t'(1)) : count_q;
	assign scan_last = ({1'b0, scan_idx_q} == CNT_W'(count_q - cnt_t'(1)));
	assign emit_go   = (state_q == ST_EMIT) && (!res_valid_q || res_ready);
	assign batch_last = ((k_q + cnt_t'(1)) == count_q);

	// Running total, saturated to the field width
	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(best_q);
	assign sum_new = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Shared distance and compare unit, fed one stored request a cycle while scanning
	sstf_dist_unit u_dist (
		.head   (head_q),
		.cand   (rd_data_s1),
		.best   (best_q),
		.found  (found_q),
		.served (marks_q[rd_idx_s1]),
		.seek   (cand_seek),
		.take   (take)
	);

	// Request store: one write port while loading, one registered read port
	always_ff @(posedge clk) begin
		if (req_fire && room) begin
			store[count_q[IDX_W-1:0]] <= req.cylinder;
		end
		rd_data_s1 <= store[scan_idx_q];
		rd_idx_s1  <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	// Payload of the candidate under test and of the result beat
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && take) begin
			best_q     <= cand_seek;
			pick_cyl_q <= rd_data_s1;
			pick_idx_q <= rd_idx_s1;
		end
		if (emit_go) begin
			res_q.served_cylinder <= pick_cyl_q;
			res_q.seek_distance   <= best_q;
			res_q.total_traversed <= sum_new;
			res_q.last_served     <= batch_last;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			scan_idx_q  <= '0;
			marks_q     <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);

			// Issue a new beat, or drop the old one once taken
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (rd_vld_s1 && take) begin
				found_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						count_q <= count_nxt;
						if (req.last_request) begin
							// Start the batch from the configured cylinder
							head_q     <= start_q;
							sum_q      <= '0;
							marks_q    <= '0;
							k_q        <= '0;
							found_q    <= 1'b0;
							scan_idx_q <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + idx_t'(1);
					end
				end
				ST_DRAIN: begin
					// Let the final candidate settle into the best registers
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						head_q     <= pick_cyl_q;
						sum_q      <= sum_new;
						found_q    <= 1'b0;
						k_q        <= k_q + cnt_t'(1);
						scan_idx_q <= '0;
						if (batch_last) begin
							// Drop the batch and reopen for loading
							count_q <= '0;
							marks_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							marks_q[pick_idx_q] <= 1'b1;
							state_q             <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sstf_disk_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF disk scheduler testbench
// Loads batches of cylinder requests through a bursty request driver, works
// out the shortest-seek service order of each batch alongside the block and
// checks every result beat, field by field, while the result side stalls on
// a pattern of its own. start_cylinder is rewritten between batch phases.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_top_tb;
	import sstf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	// Quiet cycles after the last result before touching the register or
	// ending, sized from the store depth.
	localparam int SETTLE_CYCLES  = MAX_REQUESTS + 8;
	localparam int RANDOM_PHASES  = 7;
	localparam int PHASE_ITEMS    = 55;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;

	// Requests waiting for the driver, and service beats still owed by the DUT.
	req_t pending_requests[$];
	res_t expected_services[$];

	// Shadow of the scheduler state.
	cyl_t sched_start = '0;
	cyl_t sched_store [MAX_REQUESTS];
	int   sched_count = 0;

	int mismatch_count = 0;

	sstf_disk_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0d ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Take one accepted request beat. Store it if there is room; on the
	// final request, order the whole batch nearest-first and queue one
	// service beat per held request.
	task automatic schedule_request(input req_t beat);
		logic [MAX_REQUESTS-1:0] served;
		cyl_t head;
		cyl_t seek;
		cyl_t best;
		int   pick;
		int   total;
		bit   found;
		res_t svc;
		if (sched_count < MAX_REQUESTS) begin
			sched_store[sched_count] = beat.cylinder;
			sched_count++;
		end
		if (!beat.last_request)
			return;
		head   = sched_start;
		total  = 0;
		served = '0;
		for (int k = 0; k < sched_count; k++) begin
			found = 1'b0;
			pick  = 0;
			best  = '0;
			// Scan in load order; <= lets the later request win a tie.
			for (int i = 0; i < sched_count; i++) begin
				if (served[i])
					continue;
				seek = (head >= sched_store[i]) ? head - sched_store[i]
				                                : sched_store[i] - head;
				if (!found || seek <= best) begin
					best  = seek;
					pick  = i;
					found = 1'b1;
				end
			end
			served[pick] = 1'b1;
			total += best;
			if (total > int'(SUM_MAX))
				total = int'(SUM_MAX);
			head = sched_store[pick];
			svc.served_cylinder = head;
			svc.seek_distance   = best;
			svc.total_traversed = sum_t'(total);
			svc.last_served     = (k + 1 == sched_count);
			expected_services.insert(expected_services.size(), svc);
		end
		sched_count = 0;
	endtask

	// ------------------------------------------------------------------------
	// Request driver: bursts of random length separated by random gaps. Hold
	// the beat while the DUT is not ready; advance only on a handshake.
	// ------------------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!req_valid || req_ready) begin
			if (req_valid)
				schedule_request(req);
			if (gap_left != 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req       <= pending_requests.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					// New burst; a quarter of them follow on with no gap.
					burst_left <= $urandom_range(1, 16);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor. res_ready steps through three patterns in turn:
	// always ready, ready at random, or long stretches of stall.
	// ------------------------------------------------------------------------
	int   stall_cycle;
	int   stall_left;
	res_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready   <= 1'b0;
			stall_cycle <= 0;
			stall_left  <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_services.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat, cylinder %0d",
					                          res.served_cylinder));
				end else begin
					want = expected_services.pop_front();
					if (res.served_cylinder !== want.served_cylinder)
						report_mismatch($sformatf("served_cylinder got %0d want %0d",
						                          res.served_cylinder, want.served_cylinder));
					if (res.seek_distance !== want.seek_distance)
						report_mismatch($sformatf("seek_distance got %0d want %0d",
						                          res.seek_distance, want.seek_distance));
					if (res.total_traversed !== want.total_traversed)
						report_mismatch($sformatf("total_traversed got %0d want %0d",
						                          res.total_traversed, want.total_traversed));
					if (res.last_served !== want.last_served)
						report_mismatch($sformatf("last_served got %0b want %0b",
						                          res.last_served, want.last_served));
				end
			end
			stall_cycle <= stall_cycle + 1;
			case ((stall_cycle / 256) % 3)
				0: res_ready <= 1'b1;
				1: res_ready <= ($urandom_range(0, 9) < 7);
				default: begin
					if (stall_left != 0) begin
						stall_left <= stall_left - 1;
						res_ready  <= 1'b0;
					end else begin
						if ($urandom_range(0, 3) == 0)
							stall_left <= $urandom_range(1, 24);
						res_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no beat moves on any channel for too long.
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	function automatic req_t make_req(input cyl_t cylinder, input logic last);
		req_t r;
		r.cylinder     = cylinder;
		r.last_request = last;
		return r;
	endfunction

	// Append one request to the driver's queue.
	task automatic add_request(input req_t r);
		pending_requests.insert(pending_requests.size(), r);
	endtask

	// Mix of extremes, values clustered round the head (to force ties and
	// short seeks) and full-range random cylinders.
	function automatic cyl_t pick_cylinder(input cyl_t near);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return cyl_t'(near + $urandom_range(0, 64) - 32);
			default: return cyl_t'($urandom);
		endcase
	endfunction

	task automatic queue_batch(input int n, input cyl_t near);
		for (int i = 0; i < n; i++)
			add_request(make_req(pick_cylinder(near), i == n - 1));
	endtask

	// Mostly short batches; now and then a deep one or one at or past capacity.
	function automatic int pick_batch_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return $urandom_range(1, 8);
		else if (roll < 95)
			return $urandom_range(9, MAX_REQUESTS - 1);
		else
			return $urandom_range(MAX_REQUESTS, MAX_REQUESTS + 8);
	endfunction

	// Call on a clock edge only; drive the write and wait for its handshake.
	task automatic write_start(input cyl_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sched_start = value;
		cfg_valid <= 1'b0;
	endtask

	// Drain everything queued, collect every owed result, then let the
	// scheduler settle. Check at the falling edge, once the rising-edge
	// updates of driver and monitor have all landed.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_services.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	int   queued;
	int   n;
	cyl_t phase_start;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone request at cylinder 0 with the head at 0: zero seek.
		write_start(16'h0000);
		add_request(make_req(16'h0000, 1'b1));
		// Duplicate far cylinders: equal distance, the later copy goes first.
		add_request(make_req(16'hFFFF, 1'b0));
		add_request(make_req(16'h0000, 1'b0));
		add_request(make_req(16'hFFFF, 1'b1));
		wait_drained();

		// Head at the top cylinder, sweeping down to the opposite extreme.
		write_start(16'hFFFF);
		add_request(make_req(16'h0000, 1'b0));
		add_request(make_req(16'hFFFF, 1'b0));
		add_request(make_req(16'h8000, 1'b1));
		wait_drained();

		// Symmetric neighbours round the head: each tie goes to the later load.
		write_start(16'd100);
		add_request(make_req(16'd90,  1'b0));
		add_request(make_req(16'd110, 1'b0));
		add_request(make_req(16'd100, 1'b0));
		add_request(make_req(16'd95,  1'b0));
		add_request(make_req(16'd105, 1'b1));
		wait_drained();

		// Alternating bit patterns on the start cylinder and two requests, plus all-ones and one.
		write_start(16'h5555);
		add_request(make_req(16'hAAAA, 1'b0));
		add_request(make_req(16'h5555, 1'b0));
		add_request(make_req(16'hFFFF, 1'b0));
		add_request(make_req(16'h0001, 1'b1));
		wait_drained();

		// Random phases, each under its own start cylinder. The first two
		// use the extremes, and the first also forces an overfull batch so
		// that dropped requests are always exercised.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       phase_start = 16'hFFFF;
				1:       phase_start = 16'h0000;
				default: phase_start = cyl_t'($urandom);
			endcase
			write_start(phase_start);
			queued = 0;
			if (p == 0) begin
				queue_batch(MAX_REQUESTS + 3, phase_start);
				queued += MAX_REQUESTS + 3;
			end
			while (queued < PHASE_ITEMS) begin
				n = pick_batch_size();
				queue_batch(n, phase_start);
				queued += n;
			end
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
